[sv/lse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared widths, codes, reset values and the token type that the scan front
// hands to the message assembler.
// ----------------------------------------------------------------------------
package lse_pkg;

   // Default geometry of the scan.
   localparam int MAX_DIM_DEFAULT  = 4096;
   localparam int CHANNELS_DEFAULT = 3;
   localparam int PLANES_DEFAULT   = 3;

   // Payload widths.
   localparam int SAMPLE_W  = 8;
   localparam int KIND_W    = 2;
   localparam int VALUE_W   = 32;
   localparam int BYTE_W    = 8;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   // Register reset values.
   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MESSAGE = 2'd2;

   // One extracted bit, tagged with the frame restart flag of its sample.
   typedef struct packed {
      logic restart;
      logic data_bit;
   } bit_token_type;

endpackage
`default_nettype wire

[sv/lse_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one image sample and its frame flag.
// ----------------------------------------------------------------------------
interface lse_req_if;
   import lse_pkg::*;

   logic                valid;
   logic                ready;
   logic                first;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output first, output sample, input ready);
   modport sink   (input valid, input first, input sample, output ready);

endinterface
`default_nettype wire

[sv/lse_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one extracted header field or byte.
// ----------------------------------------------------------------------------
interface lse_rsp_if;
   import lse_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink   (input valid, input kind, input value, input last, output ready);

endinterface
`default_nettype wire

[sv/lse_csr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Control register channel
// Valid/ready write channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface lse_csr_if;
   import lse_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface
`default_nettype wire

[sv/lse_scan_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Scan front
// Holds the image size registers, tracks the scan position of each sample and
// picks the bit of the current plane.
// ----------------------------------------------------------------------------
module lse_scan_front #(
   parameter int MAX_DIM  = lse_pkg::MAX_DIM_DEFAULT,
   parameter int CHANNELS = lse_pkg::CHANNELS_DEFAULT,
   parameter int PLANES   = lse_pkg::PLANES_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   lse_req_if.sink                req_if,
   lse_csr_if.sink                csr_if,
   output logic                   tok_valid,
   output lse_pkg::bit_token_type tok_data,
   input  wire                    tok_ready
);
   import lse_pkg::*;

   localparam int CW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW   = $clog2(MAX_DIM + 1);
   localparam int CMPW = ((DW > CFG_W) ? DW : CFG_W) + 1;
   localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PW   = (PLANES > 1) ? $clog2(PLANES) : 1;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in, col_cur;
   logic [CW-1:0]    row_ff, row_in, row_cur;
   logic [CHW-1:0]   chan_ff, chan_in, chan_cur;
   logic [PW-1:0]    plane_ff, plane_in, plane_cur;
   logic [CMPW-1:0]  width_lim, height_lim;
   logic [SAMPLE_W-1:0] sample_sh;
   logic             accept;

   assign req_if.ready = tok_ready;
   assign csr_if.ready = 1'b1;
   assign accept       = req_if.valid && tok_ready;
   assign tok_valid    = req_if.valid;

   // A size of zero acts as one; a size above the maximum acts as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         width_lim = CMPW'(1);
      end else if (CMPW'(width_ff) > CMPW'(MAX_DIM)) begin
         width_lim = CMPW'(MAX_DIM);
      end else begin
         width_lim = CMPW'(width_ff);
      end
      if (height_ff == '0) begin
         height_lim = CMPW'(1);
      end else if (CMPW'(height_ff) > CMPW'(MAX_DIM)) begin
         height_lim = CMPW'(MAX_DIM);
      end else begin
         height_lim = CMPW'(height_ff);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_IMAGE_WIDTH:  width_in  = csr_if.data;
            REG_IMAGE_HEIGHT: height_in = csr_if.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_cur   = req_if.first ? '0 : col_ff;
      row_cur   = req_if.first ? '0 : row_ff;
      chan_cur  = req_if.first ? '0 : chan_ff;
      plane_cur = req_if.first ? '0 : plane_ff;

      sample_sh          = req_if.sample >> plane_cur;
      tok_data.restart   = req_if.first;
      tok_data.data_bit  = sample_sh[0];

      col_in   = col_ff;
      row_in   = row_ff;
      chan_in  = chan_ff;
      plane_in = plane_ff;
      if (accept) begin
         col_in   = col_cur;
         row_in   = row_cur;
         chan_in  = chan_cur;
         plane_in = plane_cur;
         if (CMPW'(col_cur) + CMPW'(1) >= width_lim) begin
            col_in = '0;
            if (CMPW'(row_cur) + CMPW'(1) >= height_lim) begin
               row_in = '0;
               if (32'(chan_cur) + 32'd1 >= 32'(CHANNELS)) begin
                  chan_in = '0;
                  if (32'(plane_cur) + 32'd1 >= 32'(PLANES)) begin
                     plane_in = '0;
                  end else begin
                     plane_in = plane_cur + PW'(1);
                  end
               end else begin
                  chan_in = chan_cur + CHW'(1);
               end
            end else begin
               row_in = row_cur + CW'(1);
            end
         end else begin
            col_in = col_cur + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         chan_ff   <= '0;
         plane_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         chan_ff   <= chan_in;
         plane_ff  <= plane_in;
      end
   end

endmodule
`default_nettype wire

[sv/lse_bit_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bit queue
// Two-entry queue of bit tokens between the scan front and the assembler.
// ----------------------------------------------------------------------------
module lse_bit_queue (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         push_valid,
   input  wire lse_pkg::bit_token_type push_data,
   output logic                        push_ready,
   output logic                        pop_valid,
   output lse_pkg::bit_token_type      pop_data,
   input  wire                         pop_ready
);
   import lse_pkg::*;

   bit_token_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[sv/lse_assembler_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Message assembler
// Gathers bits LSB first into the length word, the file-type bytes and the
// message bytes, and drives the result register.
// ----------------------------------------------------------------------------
module lse_assembler_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         tok_valid,
   input  wire lse_pkg::bit_token_type tok_data,
   output logic                        tok_ready,
   lse_rsp_if.source                   rsp_if
);
   import lse_pkg::*;

   localparam logic [1:0] PH_LENGTH  = 2'd0;
   localparam logic [1:0] PH_TYPE    = 2'd1;
   localparam logic [1:0] PH_MESSAGE = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   logic [1:0]         phase_ff, phase_in, phase_cur;
   logic [2:0]         pos_ff, pos_in, pos_cur;
   logic [31:0]        cnt_ff, cnt_in, cnt_cur;
   logic [VALUE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic               pop, emit, fin;

   assign tok_ready    = !out_valid_ff || rsp_if.ready;
   assign pop          = tok_valid && tok_ready;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.kind  = kind_ff;
   assign rsp_if.value = value_ff;
   assign rsp_if.last  = last_ff;

   always_comb begin
      phase_cur = tok_data.restart ? PH_LENGTH : phase_ff;
      pos_cur   = tok_data.restart ? 3'd0 : pos_ff;
      cnt_cur   = tok_data.restart ? 32'd0 : cnt_ff;

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      length_in = length_ff;
      byte_in   = byte_ff;
      emit      = 1'b0;
      fin       = 1'b0;
      kind_in   = kind_ff;
      value_in  = value_ff;
      last_in   = last_ff;

      if (pop) begin
         phase_in = phase_cur;
         pos_in   = pos_cur + 3'd1;
         cnt_in   = cnt_cur;
         if (pos_cur == 3'd7) begin
            cnt_in = cnt_cur + 32'd1;
         end
         unique case (phase_cur)
            PH_LENGTH: begin
               length_in[{cnt_cur[1:0], pos_cur}] = tok_data.data_bit;
               if (pos_cur == 3'd7 && cnt_cur[1:0] == 2'd3) begin
                  emit     = 1'b1;
                  kind_in  = KIND_LENGTH;
                  value_in = length_in;
                  last_in  = 1'b0;
                  phase_in = PH_TYPE;
                  pos_in   = 3'd0;
                  cnt_in   = 32'd0;
               end
            end
            PH_TYPE, PH_MESSAGE: begin
               byte_in[pos_cur] = tok_data.data_bit;
               if (pos_cur == 3'd7) begin
                  emit = 1'b1;
                  if (phase_cur == PH_TYPE) begin
                     fin     = (cnt_cur[1:0] == 2'd3) && (length_ff == '0);
                     kind_in = KIND_TYPE;
                  end else begin
                     fin     = ({1'b0, cnt_cur} + 33'd1) >= {1'b0, length_ff};
                     kind_in = KIND_MESSAGE;
                  end
                  value_in = VALUE_W'(byte_in);
                  last_in  = fin;
                  if (fin) begin
                     phase_in = PH_DONE;
                     pos_in   = 3'd0;
                     cnt_in   = 32'd0;
                  end else if (phase_cur == PH_TYPE && cnt_cur[1:0] == 2'd3) begin
                     phase_in = PH_MESSAGE;
                     pos_in   = 3'd0;
                     cnt_in   = 32'd0;
                  end
               end
            end
            PH_DONE: begin
               pos_in = pos_cur;
               cnt_in = cnt_cur;
            end
            default: ;
         endcase
      end

      if (pop && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
      byte_ff   <= byte_in;
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LENGTH;
         pos_ff       <= 3'd0;
         cnt_ff       <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

[sv/lsb_stego_extractor_core.sv]
`default_nettype none
// Path: a result leaves on rsp_if from the result register, after the sample
// that completes it has been transferred on req_if and passed the bit queue.
// Throughput: one sample per cycle; the bit queue and the result register let
// both sides stall on their own.
// Reset: synchronous; the size registers return to 640 by 480, the scan and
// the assembler go back to the start of a frame, and the bit queue and the
// result register empty.
// ----------------------------------------------------------------------------
// LSB stego extractor core
// Recovers a message hidden in the bit planes of a streamed image: a 32-bit
// length word, four file-type bytes and then the message bytes.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_core #(
   parameter int MAX_DIM  = lse_pkg::MAX_DIM_DEFAULT,
   parameter int CHANNELS = lse_pkg::CHANNELS_DEFAULT,
   parameter int PLANES   = lse_pkg::PLANES_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   lse_req_if.sink   req_if,
   lse_csr_if.sink   csr_if,
   lse_rsp_if.source rsp_if
);
   import lse_pkg::*;

   // Front side: each sample transfer yields one token holding the selected
   // plane bit and the frame restart flag.
   logic          front_valid;
   logic          front_ready;
   bit_token_type front_tok;

   // Back side: tokens leave the queue toward the assembler.
   logic          back_valid;
   logic          back_ready;
   bit_token_type back_tok;

   // The scan front owns the size registers and the position counters, so a
   // control write never touches the assembler state.
   lse_scan_front #(
      .MAX_DIM  (MAX_DIM),
      .CHANNELS (CHANNELS),
      .PLANES   (PLANES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_if    (csr_if),
      .tok_valid (front_valid),
      .tok_data  (front_tok),
      .tok_ready (front_ready)
   );

   // The queue decouples sample intake from result back-pressure.
   lse_bit_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_tok),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_tok),
      .pop_ready  (back_ready)
   );

   // The assembler walks the length, file-type and message phases and holds
   // each finished item in its result register until it is transferred.
   lse_assembler_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (back_valid),
      .tok_data  (back_tok),
      .tok_ready (back_ready),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
